// File: sv/utt_pkg.sv
// Shared types, constants and the UTF-8 byte formatter for the UTF-16 to UTF-8 transcoder.
package utt_pkg;

    typedef enum logic [1:0] {
        ST_DATA = 2'd0,
        ST_SURR = 2'd1,
        ST_NUL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        status_t    status;
        logic       byte_last;
    } out_item_t;

    typedef struct packed {
        logic [20:0] cp;
        logic [1:0]  top;
        status_t     status;
        logic        last;
    } job_t;

    localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
    localparam logic [5:0]  SURR_LO_TAG = 6'b110111;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [15:0] LIM_1B      = 16'h0080;
    localparam logic [15:0] LIM_2B      = 16'h0800;
    localparam logic [7:0]  LEAD_2      = 8'hC0;
    localparam logic [7:0]  LEAD_3      = 8'hE0;
    localparam logic [7:0]  LEAD_4      = 8'hF0;
    localparam logic [7:0]  CONT        = 8'h80;

    function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] top,
                                             input logic [1:0] idx);
        logic [7:0] b;
        case (top)
            2'd0: b = cp[7:0];
            2'd1:
            begin
                case (idx)
                    2'd0:    b = LEAD_2 | {3'b000, cp[10:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            2'd2:
            begin
                case (idx)
                    2'd0:    b = LEAD_3 | {4'b0000, cp[15:12]};
                    2'd1:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
            default:
            begin
                case (idx)
                    2'd0:    b = LEAD_4 | {5'b00000, cp[20:18]};
                    2'd1:    b = CONT | {2'b00, cp[17:12]};
                    2'd2:    b = CONT | {2'b00, cp[11:6]};
                    default: b = CONT | {2'b00, cp[5:0]};
                endcase
            end
        endcase
        return b;
    endfunction

endpackage

// File: sv/utt_front.sv
// Front end: accepts code units, pairs surrogates, classifies errors and issues encode jobs.
module utt_front import utt_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cfg_valid,
    output logic     cfg_ready,
    input  logic     cfg_data,
    input  logic     accept,
    input  in_item_t item,
    output logic     job_push,
    output job_t     job
);

    logic       reject_nul_reg;
    logic       pend_reg;
    logic       pend_next;
    logic [9:0] held_reg;
    logic [9:0] held_next;
    logic       disc_reg;
    logic       disc_next;
    logic       err_hit;
    status_t    err_st;
    logic [15:0] cu;
    logic        last;

    assign cfg_ready = 1'b1;
    assign cu        = item.code_unit;
    assign last      = item.unit_last;

    always_comb
    begin
        job       = '0;
        job_push  = 1'b0;
        pend_next = pend_reg;
        held_next = held_reg;
        disc_next = disc_reg;
        err_hit   = 1'b0;
        err_st    = ST_SURR;
        if (accept)
        begin
            if (disc_reg)
            begin
                if (last)
                begin
                    disc_next = 1'b0;
                end
            end
            else if (pend_reg)
            begin
                pend_next = 1'b0;
                held_next = '0;
                if (cu[15:10] != SURR_LO_TAG)
                begin
                    err_hit = 1'b1;
                    err_st  = ST_SURR;
                end
                else
                begin
                    job_push = 1'b1;
                    job.cp   = SUPP_BASE + {1'b0, held_reg, cu[9:0]};
                    job.top  = 2'd3;
                    job.last = last;
                end
            end
            else if (cu == 16'h0000 && reject_nul_reg)
            begin
                err_hit = 1'b1;
                err_st  = ST_NUL;
            end
            else if (cu[15:10] == SURR_HI_TAG)
            begin
                if (last)
                begin
                    err_hit = 1'b1;
                    err_st  = ST_SURR;
                end
                else
                begin
                    held_next = cu[9:0];
                    pend_next = 1'b1;
                end
            end
            else if (cu[15:10] == SURR_LO_TAG)
            begin
                err_hit = 1'b1;
                err_st  = ST_SURR;
            end
            else
            begin
                job_push = 1'b1;
                job.cp   = {5'b00000, cu};
                job.top  = (cu < LIM_1B) ? 2'd0 : ((cu < LIM_2B) ? 2'd1 : 2'd2);
                job.last = last;
            end
            if (err_hit)
            begin
                job_push   = 1'b1;
                job.cp     = '0;
                job.top    = 2'd0;
                job.status = err_st;
                job.last   = 1'b1;
                disc_next  = !last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reject_nul_reg <= 1'b1;
            pend_reg       <= 1'b0;
            held_reg       <= '0;
            disc_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                reject_nul_reg <= cfg_data;
            end
            pend_reg <= pend_next;
            held_reg <= held_next;
            disc_reg <= disc_next;
        end
    end

endmodule

// File: sv/utt_queue.sv
// Job queue between the front end and the byte emitter.
module utt_queue import utt_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic q_push,
    input  job_t q_wdata,
    output logic q_full,
    input  logic q_pop,
    output job_t q_rdata,
    output logic q_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign q_full  = (cnt_reg == CNT_MAX);
    assign q_empty = (cnt_reg == '0);
    assign q_rdata = mem[rd_ptr_reg];
    assign do_push = q_push && !q_full;
    assign do_pop  = q_pop && !q_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: sv/utt_back.sv
// Back end: emits job UTF-8 bytes one per cycle into out_reg while empty or popped.
module utt_back import utt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  job_t      q_rdata,
    output logic      q_pop,
    input  logic      pop,
    output logic      empty,
    output out_item_t result
);

    logic      busy_reg;
    logic      busy_next;
    job_t      job_reg;
    job_t      job_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_reg;
    out_item_t out_next;
    logic      can_emit;
    logic      emit;
    logic      done;
    logic      load;

    assign can_emit = !out_valid_reg || pop;
    assign emit     = busy_reg && can_emit;
    assign done     = emit && (idx_reg == job_reg.top);
    assign load     = !q_empty && (!busy_reg || done);
    assign q_pop    = load;
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    always_comb
    begin
        busy_next      = busy_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (emit)
        begin
            out_valid_next     = 1'b1;
            out_next.out_byte  = utf8_byte(job_reg.cp, job_reg.top, idx_reg);
            out_next.status    = job_reg.status;
            out_next.byte_last = job_reg.last && (idx_reg == job_reg.top);
            idx_next           = idx_reg + 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (done)
        begin
            busy_next = 1'b0;
        end
        if (load)
        begin
            busy_next = 1'b1;
            job_next  = q_rdata;
            idx_next  = 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/utf16_to_utf8_transcoder_unit.sv
// Path: an accepted unit goes into the job queue, then the back end's job register, then the
// result register. The front end accepts one unit per cycle while the queue is not full; the
// byte emitter sends one byte a cycle while the output is empty or being popped. A code point
// yields one to four bytes; a held high surrogate or a discarded unit produces no byte.
// Reset: rst_n clears pairing, discard and queue state, empties the output; reject_nul is 1.
module utf16_to_utf8_transcoder_unit import utt_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_data,
    input  logic      push,
    output logic      full,
    input  in_item_t  utf16_word,
    input  logic      pop,
    output logic      empty,
    output out_item_t utf8_beat
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    job_t q_wdata;
    job_t q_rdata;

    assign full = q_full;

    utt_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .accept   (push && !q_full),
        .item     (utf16_word),
        .job_push (q_push),
        .job      (q_wdata)
    );

    utt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_wdata(q_wdata),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_rdata(q_rdata),
        .q_empty(q_empty)
    );

    utt_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_empty(q_empty),
        .q_rdata(q_rdata),
        .q_pop  (q_pop),
        .pop    (pop),
        .empty  (empty),
        .result (utf8_beat)
    );

endmodule

// File: sv/utt_checker.sv
// Port-level checks for the transcoder and their bind to the top level.
module utt_checker import utt_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      cfg_ready,
    input logic      pop,
    input logic      empty,
    input out_item_t utf8_beat
);

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && utf8_beat.status != ST_DATA) |->
            (utf8_beat.out_byte == 8'h00 && utf8_beat.byte_last))
    else $error("error beat carries data or lacks last");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && utf8_beat.status == ST_DATA) |-> (utf8_beat.out_byte[7:3] != 5'b11111))
    else $error("illegal UTF-8 byte value");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(utf8_beat)))
    else $error("stalled beat changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
    else $error("config channel not ready");

endmodule

bind utf16_to_utf8_transcoder_unit utt_checker u_utt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_ready(cfg_ready),
    .pop      (pop),
    .empty    (empty),
    .utf8_beat(utf8_beat)
);

// File: verif/tb.sv
// Self-checking testbench for the UTF-16 to UTF-8 transcoder: queued driver, monitor, predictor.
`timescale 1ns / 1ps

module tb import utt_pkg::*; ();

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      cfg_valid = 1'b0;
    logic      cfg_ready;
    logic      cfg_data = 1'b0;
    logic      push = 1'b0;
    logic      full;
    in_item_t  utf16_word = '0;
    logic      pop = 1'b0;
    logic      empty;
    out_item_t utf8_beat;

    in_item_t  utf16_pending[$];
    out_item_t utf8_expected[$];

    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        rx_block = 1'b0;
    int        mismatch_count = 0;
    int        beat_count = 0;

    bit          reject_nul = 1'b1;
    logic [9:0]  held_bits = '0;
    bit          high_held = 1'b0;
    bit          discarding = 1'b0;

    utf16_to_utf8_transcoder_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .utf16_word (utf16_word),
        .pop        (pop),
        .empty      (empty),
        .utf8_beat  (utf8_beat)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at beat %0d: %s got 0x%0h, want 0x%0h", beat_count, what, got, want);
        mismatch_count++;
    endtask

    task automatic emit_code_point(input logic [20:0] cp, input bit fin);
        logic [7:0] b[4];
        int         n;
        out_item_t  r;
        if (cp < 21'h80)
        begin
            b[0] = cp[7:0];
            n = 1;
        end
        else if (cp < 21'h800)
        begin
            b[0] = 8'hC0 | {3'b000, cp[10:6]};
            b[1] = 8'h80 | {2'b00, cp[5:0]};
            n = 2;
        end
        else if (cp < 21'h10000)
        begin
            b[0] = 8'hE0 | {4'b0000, cp[15:12]};
            b[1] = 8'h80 | {2'b00, cp[11:6]};
            b[2] = 8'h80 | {2'b00, cp[5:0]};
            n = 3;
        end
        else
        begin
            b[0] = 8'hF0 | {5'b00000, cp[20:18]};
            b[1] = 8'h80 | {2'b00, cp[17:12]};
            b[2] = 8'h80 | {2'b00, cp[11:6]};
            b[3] = 8'h80 | {2'b00, cp[5:0]};
            n = 4;
        end
        for (int k = 0; k < n; k++)
        begin
            r.out_byte  = b[k];
            r.status    = ST_DATA;
            r.byte_last = fin && (k == n - 1);
            utf8_expected = {utf8_expected, r};
        end
    endtask

    task automatic flag_fault(input status_t st, input bit fin);
        out_item_t r;
        high_held  = 1'b0;
        held_bits  = '0;
        discarding = !fin;
        r.out_byte  = 8'h00;
        r.status    = st;
        r.byte_last = 1'b1;
        utf8_expected = {utf8_expected, r};
    endtask

    task automatic transcode_unit(input in_item_t w);
        logic [15:0] cu;
        bit          fin;
        cu  = w.code_unit;
        fin = w.unit_last;
        if (discarding)
        begin
            if (fin)
                discarding = 1'b0;
        end
        else if (high_held)
        begin
            if (cu < 16'hDC00 || cu > 16'hDFFF)
                flag_fault(ST_SURR, fin);
            else
            begin
                high_held = 1'b0;
                emit_code_point(21'h10000 + {1'b0, held_bits, cu[9:0]}, fin);
                held_bits = '0;
            end
        end
        else if (cu == 16'h0000 && reject_nul)
            flag_fault(ST_NUL, fin);
        else if (cu >= 16'hD800 && cu <= 16'hDBFF)
        begin
            if (fin)
                flag_fault(ST_SURR, fin);
            else
            begin
                held_bits = cu[9:0];
                high_held = 1'b1;
            end
        end
        else if (cu >= 16'hDC00 && cu <= 16'hDFFF)
            flag_fault(ST_SURR, fin);
        else
            emit_code_point({5'd0, cu}, fin);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                transcode_unit(utf16_word);
            if (!push || !full)
            begin
                if (utf16_pending.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    push       <= 1'b1;
                    utf16_word <= utf16_pending.pop_front();
                end
                else
                    push <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (utf8_expected.size() == 0)
                    report_mismatch("unexpected beat, byte", int'(utf8_beat.out_byte), 0);
                else
                begin
                    out_item_t want;
                    want = utf8_expected.pop_front();
                    if (utf8_beat.out_byte !== want.out_byte)
                        report_mismatch("out_byte", int'(utf8_beat.out_byte),
                                        int'(want.out_byte));
                    if (utf8_beat.status !== want.status)
                        report_mismatch("status", int'(utf8_beat.status), int'(want.status));
                    if (utf8_beat.byte_last !== want.byte_last)
                        report_mismatch("byte_last", int'(utf8_beat.byte_last),
                                        int'(want.byte_last));
                end
                beat_count++;
            end
            pop <= !rx_block && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_unit(input logic [15:0] cu, input bit fin);
        in_item_t w;
        w.code_unit = cu;
        w.unit_last = fin;
        utf16_pending = {utf16_pending, w};
    endtask

    task automatic queue_random_units(input int target);
        int added;
        int len;
        int kind;
        bit fin;
        added = 0;
        while (added < target)
        begin
            len = $urandom_range(1, 6);
            for (int k = 0; k < len; k++)
            begin
                fin  = (k == len - 1);
                kind = $urandom_range(99);
                if (kind < 5)
                    queue_unit(16'h0000, fin);
                else if (kind < 30)
                    queue_unit(16'($urandom_range(16'h01, 16'h7F)), fin);
                else if (kind < 50)
                    queue_unit(16'($urandom_range(16'h080, 16'h7FF)), fin);
                else if (kind < 65)
                begin
                    if ($urandom_range(1))
                        queue_unit(16'($urandom_range(16'h0800, 16'hD7FF)), fin);
                    else
                        queue_unit(16'($urandom_range(16'hE000, 16'hFFFF)), fin);
                end
                else if (kind < 85)
                begin
                    queue_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
                    queue_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), fin);
                    added++;
                end
                else if (kind < 90)
                    queue_unit(16'($urandom_range(16'hD800, 16'hDBFF)), fin);
                else if (kind < 95)
                    queue_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), fin);
                else
                    queue_unit(16'($urandom_range(16'hFFFF)), fin);
                added++;
            end
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (utf16_pending.size() != 0 || push || utf8_expected.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_reject_nul(input bit value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid  <= 1'b0;
        reject_nul = value;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 7;
        recv_idle_pct = 58;
        queue_unit(16'h0041, 1'b0);
        queue_unit(16'h007F, 1'b0);
        queue_unit(16'h0080, 1'b0);
        queue_unit(16'h07FF, 1'b0);
        queue_unit(16'h0800, 1'b0);
        queue_unit(16'hFFFF, 1'b1);
        queue_unit(16'h0000, 1'b1);
        queue_unit(16'h0000, 1'b0);
        queue_unit(16'h0041, 1'b0);
        queue_unit(16'h0042, 1'b1);
        queue_unit(16'hD800, 1'b0);
        queue_unit(16'hDC00, 1'b1);
        queue_unit(16'hDBFF, 1'b0);
        queue_unit(16'hDFFF, 1'b1);
        queue_unit(16'hD800, 1'b0);
        queue_unit(16'h0041, 1'b0);
        queue_unit(16'h0000, 1'b1);
        queue_unit(16'hD800, 1'b0);
        queue_unit(16'h0000, 1'b1);
        queue_unit(16'hDBFF, 1'b1);
        queue_unit(16'hDC00, 1'b1);
        queue_unit(16'hDFFF, 1'b0);
        queue_unit(16'hD800, 1'b1);
        queue_unit(16'hD7FF, 1'b0);
        queue_unit(16'hE000, 1'b1);
        wait_drained();

        write_reject_nul(1'b0);
        queue_unit(16'h0000, 1'b1);
        queue_random_units(100);
        @(negedge clk);
        rx_block = 1'b1;
        repeat (200) @(negedge clk);
        rx_block = 1'b0;
        wait_drained();

        write_reject_nul(1'b1);
        send_idle_pct = 58;
        recv_idle_pct = 7;
        queue_random_units(50);
        wait_drained();
        queue_random_units(50);
        wait_drained();

        write_reject_nul(1'b0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random_units(100);
        wait_drained();

        repeat (20) @(negedge clk);
        if (utf8_expected.size() != 0)
            report_mismatch("beats left over", utf8_expected.size(), 0);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
